// ===== design/life_cellular_automaton_assert.svh =====
// ---------------------------------------------------------------------------
// Life automaton assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_ASSERT_SVH
`define LIFE_CELLULAR_AUTOMATON_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("life automaton check failed");

// next-cycle implication, disabled during reset
`define LCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("life automaton check failed");

`endif

// ===== design/lca_pkg.sv =====
// ---------------------------------------------------------------------------
// Life automaton package
// Grid dimensions, command codes, sequencer states and cell control.
// ---------------------------------------------------------------------------
package lca_pkg;

  localparam int NUM_ROWS = 32;
  localparam int NUM_COLS = 32;
  localparam int ROW_W    = $clog2(NUM_ROWS);
  localparam int COL_W    = $clog2(NUM_COLS);
  localparam int DIM_W    = 6;
  localparam int GEN_W    = 8;
  localparam int CMD_W    = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic             wr_val;
    logic [COL_W-1:0] column;
  } cell_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [NUM_COLS-1:0] col_mask(input logic [DIM_W-1:0] cols);
    logic [NUM_COLS-1:0] m;
    for (int j = 0; j < NUM_COLS; j++) m[j] = (j < int'(cols));
    return m;
  endfunction

endpackage

// ===== design/lca_cell.sv =====
// ---------------------------------------------------------------------------
// Life automaton row cell
// Holds one grid row; shifts from its neighbour or updates one bit.
// ---------------------------------------------------------------------------
module lca_cell
  import lca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic                sel,
  input  logic [NUM_COLS-1:0] nbr_row,
  output logic [NUM_COLS-1:0] row_q
);

  logic [NUM_COLS-1:0] row_r;
  logic [NUM_COLS-1:0] row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctrl.shift) begin
      row_nxt = nbr_row;
    end else if (ctrl.wr_en && sel) begin
      row_nxt[ctrl.column] = ctrl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

// ===== design/lca_rule.sv =====
// ---------------------------------------------------------------------------
// Life automaton row rule
// B3/S23 update of one row from the rows above and below; passes it through when inactive.
// ---------------------------------------------------------------------------
module lca_rule
  import lca_pkg::*;
(
  input  logic [NUM_COLS-1:0] up,
  input  logic [NUM_COLS-1:0] mid,
  input  logic [NUM_COLS-1:0] down,
  input  logic [NUM_COLS-1:0] mask,
  input  logic                active,
  output logic [NUM_COLS-1:0] nxt
);

  logic [NUM_COLS+1:0] u_x;
  logic [NUM_COLS+1:0] m_x;
  logic [NUM_COLS+1:0] d_x;
  logic [NUM_COLS-1:0] life;
  logic [3:0]          cnt [NUM_COLS];

  // zero pad so the outer edges see dead neighbours
  assign u_x = {1'b0, up & mask, 1'b0};
  assign m_x = {1'b0, mid & mask, 1'b0};
  assign d_x = {1'b0, down & mask, 1'b0};

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      cnt[c] = 4'(u_x[c]) + 4'(u_x[c+1]) + 4'(u_x[c+2])
             + 4'(m_x[c]) + 4'(m_x[c+2])
             + 4'(d_x[c]) + 4'(d_x[c+1]) + 4'(d_x[c+2]);
      life[c] = (cnt[c] == 4'd3) || ((cnt[c] == 4'd2) && m_x[c+1]);
    end
  end

  assign nxt = active ? ((mid & ~mask) | (life & mask)) : mid;

endmodule

// ===== design/life_cellular_automaton.sv =====
// ---------------------------------------------------------------------------
// Life cellular automaton
// Bounded B3/S23 grid in a ring of row cells with one shared row rule.
// ---------------------------------------------------------------------------
// Input items on in_*: set cell, clear cell, advance N generations, read row.
// Every item returns one result on out_*: the addressed row after the
// command, active columns only, zero if the row is outside the active area.
// cfg_* writes rows_in_use (index 0) and columns_in_use (index 1); values are
// clamped to 2..32 on write. Write only while idle.
// Sequence: set, clear, read and zero-generation advance pass from accept
// through the EXEC and RESP states into the output register; advance of g
// generations runs in RUN between them, the ring of 32 row cells rotating
// once through the row rule per generation. in_tready is high only in idle,
// so one item is in work at a time. A new item is taken while the previous
// result still waits.
// If out_tready stays low the sequencer holds its next result until the
// output register empties. Reset clears the grid, empties the output and
// sets both dimensions to 32.
// ---------------------------------------------------------------------------
module life_cellular_automaton
  import lca_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command[1:0], row[6:2], column[11:7], generations[19:12]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // row_bits[31:0]
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [ROW_W-1:0]    arow_r;
  logic [COL_W-1:0]    acol_r;
  logic [GEN_W-1:0]    gens_r, gens_nxt;
  logic [ROW_W-1:0]    step_r, step_nxt;
  logic [NUM_COLS-1:0] prev_r;
  logic [DIM_W-1:0]    rows_eff_r;
  logic [DIM_W-1:0]    cols_eff_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;

  logic                accept;
  logic                load_out;
  logic                in_area;
  logic                row_hit;
  logic [NUM_COLS-1:0] mask;
  logic [NUM_COLS-1:0] rd_row;
  logic [NUM_COLS-1:0] up_row;
  logic [NUM_COLS-1:0] down_row;
  logic [NUM_COLS-1:0] new_row;
  logic                rule_active;
  cell_ctrl_t          ctrl;
  logic [NUM_COLS-1:0] cell_q [NUM_ROWS];

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign mask      = col_mask(cols_eff_r);
  assign row_hit   = ({1'b0, arow_r} < rows_eff_r);
  assign in_area   = row_hit && ({1'b0, acol_r} < cols_eff_r);
  assign rd_row    = row_hit ? (cell_q[arow_r] & mask) : '0;

  // ring: logical row step_r sits in cell 0, its lower neighbour in cell 1
  assign up_row      = (step_r != '0) ? prev_r : '0;
  assign down_row    = (({1'b0, step_r} + DIM_W'(1)) < rows_eff_r) ? cell_q[1] : '0;
  assign rule_active = ({1'b0, step_r} < rows_eff_r);

  lca_rule u_rule (
    .up     (up_row),
    .mid    (cell_q[0]),
    .down   (down_row),
    .mask   (mask),
    .active (rule_active),
    .nxt    (new_row)
  );

  for (genvar i = 0; i < NUM_ROWS; i++) begin : g_cell
    logic [NUM_COLS-1:0] nbr;
    if (i == NUM_ROWS - 1) begin : g_tail
      assign nbr = new_row;
    end else begin : g_body
      assign nbr = cell_q[i+1];
    end
    lca_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .sel     (arow_r == ROW_W'(i)),
      .nbr_row (nbr),
      .row_q   (cell_q[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    gens_nxt    = gens_r;
    step_nxt    = step_r;
    load_out    = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.wr_en  = 1'b0;
    ctrl.wr_val = (cmd_r == CMD_SET);
    ctrl.column = acol_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if ((cmd_r == CMD_ADVANCE) && (gens_r != '0)) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end else begin
          state_nxt  = ST_RESP;
          ctrl.wr_en = in_area && ((cmd_r == CMD_SET) || (cmd_r == CMD_CLEAR));
        end
      end
      ST_RUN: begin
        ctrl.shift = 1'b1;
        if (step_r == ROW_W'(NUM_ROWS - 1)) begin
          step_nxt = '0;
          gens_nxt = gens_r - GEN_W'(1);
          if (gens_r == GEN_W'(1)) state_nxt = ST_RESP;
        end else begin
          step_nxt = step_r + ROW_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rows_eff_r  <= DIM_W'(NUM_ROWS);
      cols_eff_r  <= DIM_W'(NUM_COLS);
      step_r      <= '0;
      gens_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      gens_r      <= accept ? in_tdata[19:12] : gens_nxt;
      if (cfg_wr_en && (cfg_index == CFG_ROWS)) begin
        rows_eff_r <= clamp_dim(cfg_wdata, DIM_W'(NUM_ROWS));
      end
      if (cfg_wr_en && (cfg_index == CFG_COLS)) begin
        cols_eff_r <= clamp_dim(cfg_wdata, DIM_W'(NUM_COLS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_tdata[1:0]);
      arow_r <= in_tdata[6:2];
      acol_r <= in_tdata[11:7];
    end
    if (ctrl.shift) prev_r <= cell_q[0];
    if (load_out) out_data_r <= OUT_W'(rd_row);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/lca_checker.sv =====
// ---------------------------------------------------------------------------
// Life automaton port checker
// Port-level checks on the top level, attached by bind.
// ---------------------------------------------------------------------------
`include "life_cellular_automaton_assert.svh"

module lca_checker
  import lca_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  `LCA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `LCA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `LCA_ASSERT_NOW(a_result_from_busy, $rose(out_tvalid), !$past(in_tready))

endmodule

bind life_cellular_automaton lca_checker u_lca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
